// ===== sv/oas_pkg.sv =====
// Shared types and constants for the obstacle avoidance sequencer.
package oas_pkg;

	// phase codes
	localparam logic [2:0] PH_FORWARD    = 3'd0;
	localparam logic [2:0] PH_BRAKE_BACK = 3'd1;
	localparam logic [2:0] PH_REVERSE    = 3'd2;
	localparam logic [2:0] PH_BRAKE_TURN = 3'd3;
	localparam logic [2:0] PH_TURN       = 3'd4;
	localparam logic [2:0] PH_SETTLE     = 3'd5;
	localparam logic [2:0] PH_CHECK      = 3'd6;

	// configuration register indexes
	localparam logic [2:0] REG_LIMIT_MM      = 3'd0;
	localparam logic [2:0] REG_BRAKE_MS      = 3'd1;
	localparam logic [2:0] REG_REVERSE_MS    = 3'd2;
	localparam logic [2:0] REG_TURN_MS       = 3'd3;
	localparam logic [2:0] REG_SETTLE_MS     = 3'd4;
	localparam logic [2:0] REG_FORWARD_SPEED = 3'd5;
	localparam logic [2:0] REG_REVERSE_SPEED = 3'd6;
	localparam logic [2:0] REG_TURN_SPEED    = 3'd7;

	// register reset values
	localparam logic [11:0] RST_LIMIT_MM   = 12'd200;
	localparam logic [15:0] RST_BRAKE_MS   = 16'd100;
	localparam logic [15:0] RST_REVERSE_MS = 16'd300;
	localparam logic [15:0] RST_TURN_MS    = 16'd650;
	localparam logic [15:0] RST_SETTLE_MS  = 16'd300;
	localparam logic [6:0]  RST_SPEED      = 7'd60;

	typedef struct packed {
		logic        restart;
		logic [7:0]  elapsed_ms;
		logic [11:0] range_mm;
	} oas_in_t;

	typedef struct packed {
		logic              motor_write;
		logic signed [7:0] left_speed;
		logic signed [7:0] right_speed;
		logic [2:0]        phase;
		logic              range_used;
	} oas_out_t;

	typedef struct packed {
		logic [11:0] limit_mm;
		logic [15:0] brake_ms;
		logic [15:0] reverse_ms;
		logic [15:0] turn_ms;
		logic [15:0] settle_ms;
		logic [6:0]  forward_speed;
		logic [6:0]  reverse_speed;
		logic [6:0]  turn_speed;
	} oas_cfg_t;

endpackage

// ===== sv/oas_regs.sv =====
// Configuration register file of the obstacle avoidance sequencer.
module oas_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output oas_pkg::oas_cfg_t cfg
);
	import oas_pkg::*;

	oas_cfg_t cfg_q;

	// write one register per accepted configuration item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_mm      <= RST_LIMIT_MM;
			cfg_q.brake_ms      <= RST_BRAKE_MS;
			cfg_q.reverse_ms    <= RST_REVERSE_MS;
			cfg_q.turn_ms       <= RST_TURN_MS;
			cfg_q.settle_ms     <= RST_SETTLE_MS;
			cfg_q.forward_speed <= RST_SPEED;
			cfg_q.reverse_speed <= RST_SPEED;
			cfg_q.turn_speed    <= RST_SPEED;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LIMIT_MM:      cfg_q.limit_mm      <= wr_data[11:0];
				REG_BRAKE_MS:      cfg_q.brake_ms      <= wr_data;
				REG_REVERSE_MS:    cfg_q.reverse_ms    <= wr_data;
				REG_TURN_MS:       cfg_q.turn_ms       <= wr_data;
				REG_SETTLE_MS:     cfg_q.settle_ms     <= wr_data;
				REG_FORWARD_SPEED: cfg_q.forward_speed <= wr_data[6:0];
				REG_REVERSE_SPEED: cfg_q.reverse_speed <= wr_data[6:0];
				REG_TURN_SPEED:    cfg_q.turn_speed    <= wr_data[6:0];
				default:           cfg_q.limit_mm      <= cfg_q.limit_mm;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/oas_fsm.sv =====
// Phase sequencer and one-shot timer: computes one result per accepted poll.
module oas_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  oas_pkg::oas_in_t  poll,
	input  oas_pkg::oas_cfg_t cfg,
	output oas_pkg::oas_out_t result
);
	import oas_pkg::*;

	logic [2:0]  phase_q;
	logic [15:0] timer_left_q;
	logic        timer_armed_q;

	logic [2:0]        phase_d;
	logic [15:0]       timer_left_d;
	logic              timer_armed_d;
	logic              fired;
	logic              clear;
	logic              wr;
	logic signed [7:0] left_d;
	logic signed [7:0] right_d;
	logic              sampled;
	logic signed [7:0] fwd;
	logic signed [7:0] rev_n;
	logic signed [7:0] trn;
	logic signed [7:0] trn_n;

	assign fwd   = {1'b0, cfg.forward_speed};
	assign rev_n = 8'sd0 - {1'b0, cfg.reverse_speed};
	assign trn   = {1'b0, cfg.turn_speed};
	assign trn_n = 8'sd0 - trn;
	assign clear = poll.range_mm > cfg.limit_mm;

	// next phase, timer and motor command
	always_comb begin
		phase_d       = phase_q;
		timer_left_d  = timer_left_q;
		timer_armed_d = timer_armed_q;
		fired         = 1'b0;
		wr            = 1'b0;
		left_d        = 8'sd0;
		right_d       = 8'sd0;
		sampled       = 1'b0;
		if (poll.restart) begin
			phase_d       = PH_FORWARD;
			timer_left_d  = 16'd0;
			timer_armed_d = 1'b0;
			wr            = 1'b1;
		end else begin
			// count the timer down, fire when elapsed covers what is left
			if (timer_armed_q) begin
				if ({8'd0, poll.elapsed_ms} >= timer_left_q) begin
					fired         = 1'b1;
					timer_armed_d = 1'b0;
					timer_left_d  = 16'd0;
				end else begin
					timer_left_d = timer_left_q - {8'd0, poll.elapsed_ms};
				end
			end
			unique case (phase_q)
				PH_FORWARD: begin
					sampled = 1'b1;
					wr      = 1'b1;
					if (clear) begin
						left_d  = fwd;
						right_d = fwd;
					end else begin
						phase_d       = PH_BRAKE_BACK;
						timer_left_d  = cfg.brake_ms;
						timer_armed_d = 1'b1;
					end
				end
				PH_BRAKE_BACK: begin
					if (fired) begin
						wr            = 1'b1;
						left_d        = rev_n;
						right_d       = rev_n;
						phase_d       = PH_REVERSE;
						timer_left_d  = cfg.reverse_ms;
						timer_armed_d = 1'b1;
					end
				end
				PH_REVERSE: begin
					if (fired) begin
						wr            = 1'b1;
						phase_d       = PH_BRAKE_TURN;
						timer_left_d  = cfg.brake_ms;
						timer_armed_d = 1'b1;
					end
				end
				PH_BRAKE_TURN: begin
					if (fired) begin
						wr            = 1'b1;
						left_d        = trn_n;
						right_d       = trn;
						phase_d       = PH_TURN;
						timer_left_d  = cfg.turn_ms;
						timer_armed_d = 1'b1;
					end
				end
				PH_TURN: begin
					if (fired) begin
						wr            = 1'b1;
						phase_d       = PH_SETTLE;
						timer_left_d  = cfg.settle_ms;
						timer_armed_d = 1'b1;
					end
				end
				PH_SETTLE: begin
					if (fired) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					sampled = 1'b1;
					wr      = 1'b1;
					if (clear) begin
						left_d  = fwd;
						right_d = fwd;
						phase_d = PH_FORWARD;
					end else begin
						left_d        = trn_n;
						right_d       = trn;
						phase_d       = PH_TURN;
						timer_left_d  = cfg.turn_ms;
						timer_armed_d = 1'b1;
					end
				end
				default: begin
					// unreachable code: hold the phase, issue nothing
					phase_d = phase_q;
				end
			endcase
		end
	end

	// advance the state on each accepted poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FORWARD;
			timer_left_q  <= 16'd0;
			timer_armed_q <= 1'b0;
		end else if (accept) begin
			phase_q       <= phase_d;
			timer_left_q  <= timer_left_d;
			timer_armed_q <= timer_armed_d;
		end
	end

	always_comb begin
		result.motor_write = wr;
		result.left_speed  = left_d;
		result.right_speed = right_d;
		result.phase       = phase_d;
		result.range_used  = sampled;
	end

endmodule

// ===== sv/obstacle_avoid_sequencer_core.sv =====
// Top level of the obstacle avoidance sequencer: config port, sequencer, result register.
// Each accepted poll yields one result item in the output register in the cycle after it; a new
// poll is taken every cycle as long as the output register is empty or being drained.
// The whole phase and timer update is one combinational step between the input channel
// and the result register, so the rate is one poll per clock unless stalled. Configuration writes are
// always ready and take effect on the next poll.
module obstacle_avoid_sequencer_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  oas_pkg::oas_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output oas_pkg::oas_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import oas_pkg::*;

	oas_cfg_t cfg;
	oas_out_t result;
	oas_out_t out_q;
	logic     out_valid_q;
	logic     accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;

	oas_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	oas_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.poll   (in_data),
		.cfg    (cfg),
		.result (result)
	);

	// hold the result item until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== tb/sv/tb_obstacle_avoid_sequencer_core.sv =====
// Testbench for the obstacle avoidance sequencer: random polls, config sweeps, motor command check.
`timescale 1ns / 100ps

module tb_obstacle_avoid_sequencer_core;
	import oas_pkg::*;

	// Track the phase and timer of the car and hold the motor commands still due.
	class motor_cmd_board;
		oas_cfg_t   regs_now;
		logic [2:0] phase_now;
		logic [15:0] timer_left;
		logic       timer_armed;
		oas_out_t   cmd_due[$];
		int         mismatches;

		function new();
			regs_now.limit_mm      = RST_LIMIT_MM;
			regs_now.brake_ms      = RST_BRAKE_MS;
			regs_now.reverse_ms    = RST_REVERSE_MS;
			regs_now.turn_ms       = RST_TURN_MS;
			regs_now.settle_ms     = RST_SETTLE_MS;
			regs_now.forward_speed = RST_SPEED;
			regs_now.reverse_speed = RST_SPEED;
			regs_now.turn_speed    = RST_SPEED;
			phase_now   = PH_FORWARD;
			timer_left  = '0;
			timer_armed = 1'b0;
			mismatches  = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_LIMIT_MM:      regs_now.limit_mm      = val[11:0];
				REG_BRAKE_MS:      regs_now.brake_ms      = val;
				REG_REVERSE_MS:    regs_now.reverse_ms    = val;
				REG_TURN_MS:       regs_now.turn_ms       = val;
				REG_SETTLE_MS:     regs_now.settle_ms     = val;
				REG_FORWARD_SPEED: regs_now.forward_speed = val[6:0];
				REG_REVERSE_SPEED: regs_now.reverse_speed = val[6:0];
				REG_TURN_SPEED:    regs_now.turn_speed    = val[6:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return cmd_due.size();
		endfunction

		function void start_timer(logic [15:0] ms);
			timer_left  = ms;
			timer_armed = 1'b1;
		endfunction

		// Advance the sequencer by one accepted poll and queue the command it yields.
		function void note_poll(oas_in_t p);
			oas_out_t          r;
			logic              fired;
			logic              clear;
			logic signed [7:0] fwd;
			logic signed [7:0] rev;
			logic signed [7:0] trn;
			r     = '0;
			fired = 1'b0;
			fwd   = {1'b0, regs_now.forward_speed};
			rev   = {1'b0, regs_now.reverse_speed};
			trn   = {1'b0, regs_now.turn_speed};
			clear = p.range_mm > regs_now.limit_mm;
			if (p.restart) begin
				phase_now     = PH_FORWARD;
				timer_left    = '0;
				timer_armed   = 1'b0;
				r.motor_write = 1'b1;
			end else begin
				// count the timer down; firing disarms it
				if (timer_armed) begin
					if ({8'd0, p.elapsed_ms} >= timer_left) begin
						fired       = 1'b1;
						timer_armed = 1'b0;
						timer_left  = '0;
					end else begin
						timer_left = timer_left - {8'd0, p.elapsed_ms};
					end
				end
				case (phase_now)
					PH_FORWARD: begin
						r.range_used  = 1'b1;
						r.motor_write = 1'b1;
						if (clear) begin
							r.left_speed  = fwd;
							r.right_speed = fwd;
						end else begin
							phase_now = PH_BRAKE_BACK;
							start_timer(regs_now.brake_ms);
						end
					end
					PH_BRAKE_BACK: if (fired) begin
						r.motor_write = 1'b1;
						r.left_speed  = -rev;
						r.right_speed = -rev;
						phase_now     = PH_REVERSE;
						start_timer(regs_now.reverse_ms);
					end
					PH_REVERSE: if (fired) begin
						r.motor_write = 1'b1;
						phase_now     = PH_BRAKE_TURN;
						start_timer(regs_now.brake_ms);
					end
					PH_BRAKE_TURN: if (fired) begin
						r.motor_write = 1'b1;
						r.left_speed  = -trn;
						r.right_speed = trn;
						phase_now     = PH_TURN;
						start_timer(regs_now.turn_ms);
					end
					PH_TURN: if (fired) begin
						r.motor_write = 1'b1;
						phase_now     = PH_SETTLE;
						start_timer(regs_now.settle_ms);
					end
					PH_SETTLE: if (fired) begin
						phase_now = PH_CHECK;
					end
					PH_CHECK: begin
						r.range_used  = 1'b1;
						r.motor_write = 1'b1;
						if (clear) begin
							r.left_speed  = fwd;
							r.right_speed = fwd;
							phase_now     = PH_FORWARD;
						end else begin
							r.left_speed  = -trn;
							r.right_speed = trn;
							phase_now     = PH_TURN;
							start_timer(regs_now.turn_ms);
						end
					end
					default: ;
				endcase
			end
			r.phase = phase_now;
			cmd_due.push_back(r);
		endfunction

		function void cmp(string field, int want, int got);
			if (want != got) begin
				$error("%s expected %0d actual %0d", field, want, got);
				mismatches++;
			end
		endfunction

		// Compare a result item with the oldest command due.
		function void check_cmd(oas_out_t got);
			oas_out_t want;
			if (cmd_due.size() == 0) begin
				$error("result item with no poll waiting for it");
				mismatches++;
				return;
			end
			want = cmd_due.pop_front();
			cmp("motor_write", int'(want.motor_write), int'(got.motor_write));
			cmp("left_speed", int'($signed(want.left_speed)), int'($signed(got.left_speed)));
			cmp("right_speed", int'($signed(want.right_speed)), int'($signed(got.right_speed)));
			cmp("phase", int'(want.phase), int'(got.phase));
			cmp("range_used", int'(want.range_used), int'(got.range_used));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	oas_in_t     in_data;
	logic        out_valid;
	logic        out_stall;
	oas_out_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	motor_cmd_board board;
	int burst_left;
	int hold_reqs;

	obstacle_avoid_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Give up on a hung run.
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// Watch both channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_cmd(out_data);
			if (in_valid && !in_stall)
				board.note_poll(in_data);
		end
	end

	// Stall the result channel in modes of random length, with long holds on request.
	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		int holds_done;
		out_stall  = 1'b0;
		mode       = 0;
		mode_left  = 0;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_reqs) begin
				holds_done++;
				hold_left = 80;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= mode_left[0];
				endcase
			end
		end
	end

	// Offer one poll, opening a gap of random length, possibly none, between bursts.
	task automatic send_poll(oas_in_t p);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop sending and wait for every command due.
	task automatic drain_cmds();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
	endtask

	task automatic load_cfg(oas_cfg_t c);
		write_reg(REG_LIMIT_MM, {4'd0, c.limit_mm});
		write_reg(REG_BRAKE_MS, c.brake_ms);
		write_reg(REG_REVERSE_MS, c.reverse_ms);
		write_reg(REG_TURN_MS, c.turn_ms);
		write_reg(REG_SETTLE_MS, c.settle_ms);
		write_reg(REG_FORWARD_SPEED, {9'd0, c.forward_speed});
		write_reg(REG_REVERSE_SPEED, {9'd0, c.reverse_speed});
		write_reg(REG_TURN_SPEED, {9'd0, c.turn_speed});
		cfg_valid <= 1'b0;
	endtask

	function automatic oas_in_t poll(logic rs, int ms, int mm);
		oas_in_t p;
		p.restart    = rs;
		p.elapsed_ms = ms[7:0];
		p.range_mm   = mm[11:0];
		return p;
	endfunction

	// Random poll with the range placed around the current threshold.
	function automatic oas_in_t random_poll();
		int lim;
		int ms;
		int mm;
		int k;
		lim = int'(board.regs_now.limit_mm);
		k   = $urandom_range(0, 9);
		if (k == 0)
			ms = 0;
		else if (k == 1)
			ms = 255;
		else if (k < 6)
			ms = $urandom_range(0, 40);
		else
			ms = $urandom_range(0, 255);
		k = $urandom_range(0, 9);
		case (k)
			0, 1, 2: mm = (lim < 4095) ? $urandom_range(lim + 1, 4095) : 4095;
			3, 4, 5: mm = $urandom_range(0, lim);
			6:       mm = lim;
			7:       mm = lim + 1;
			8:       mm = 0;
			default: mm = $urandom_range(0, 4095);
		endcase
		return poll($urandom_range(0, 32) == 0, ms, mm);
	endfunction

	function automatic oas_cfg_t random_cfg();
		oas_cfg_t c;
		c.limit_mm      = 12'($urandom_range(0, 4095));
		c.brake_ms      = 16'($urandom_range(0, 600));
		c.reverse_ms    = 16'($urandom_range(0, 600));
		c.turn_ms       = 16'($urandom_range(0, 600));
		c.settle_ms     = 16'($urandom_range(0, 600));
		c.forward_speed = 7'($urandom_range(0, 127));
		c.reverse_speed = 7'($urandom_range(0, 127));
		c.turn_speed    = 7'($urandom_range(0, 127));
		return c;
	endfunction

	initial begin : main
		oas_in_t  warmup[$];
		oas_cfg_t sweep[5];
		board      = new();
		burst_left = 0;
		hold_reqs  = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;

		// threshold and durations at their extremes, then random settings
		sweep[0] = '{limit_mm: 12'd0, brake_ms: 16'd0, reverse_ms: 16'd0, turn_ms: 16'd0,
			settle_ms: 16'd0, forward_speed: 7'd127, reverse_speed: 7'd0, turn_speed: 7'd100};
		sweep[1] = '{limit_mm: 12'd4095, brake_ms: 16'd0, reverse_ms: 16'hffff, turn_ms: 16'd1,
			settle_ms: 16'hffff, forward_speed: 7'd100, reverse_speed: 7'd127, turn_speed: 7'd1};
		for (int i = 2; i < 5; i++)
			sweep[i] = random_cfg();

		// walk one full avoidance cycle at reset settings, with a restart and a second turn
		warmup = '{poll(0, 0, 4095), poll(0, 255, 201), poll(0, 10, 200), poll(0, 255, 0),
			poll(1, 255, 4095), poll(0, 0, 0), poll(0, 255, 77), poll(0, 255, 3000),
			poll(0, 45, 12), poll(0, 255, 0), poll(0, 255, 1), poll(0, 255, 2),
			poll(0, 140, 3), poll(0, 255, 4), poll(0, 45, 5), poll(0, 0, 100),
			poll(0, 255, 6), poll(0, 255, 7), poll(0, 140, 8), poll(0, 255, 9),
			poll(0, 255, 10), poll(0, 7, 4095), poll(0, 128, 2048)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (warmup[i])
			send_poll(warmup[i]);
		for (int n = 0; n < 290; n++)
			send_poll(random_poll());
		drain_cmds();

		for (int s = 0; s < 5; s++) begin
			load_cfg(sweep[s]);
			for (int n = 0; n < 290; n++) begin
				// hold the result channel off while polls keep coming
				if (s == 2 && n == 100)
					hold_reqs <= hold_reqs + 1;
				send_poll(random_poll());
			end
			drain_cmds();
		end

		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
